// File: src/baro_temp_pressure_compensation_assert.svh
// Assertion macros for the compensation block
`ifndef BARO_TEMP_PRESSURE_COMPENSATION_ASSERT_SVH
`define BARO_TEMP_PRESSURE_COMPENSATION_ASSERT_SVH
// implication checked on every rising clock edge, disabled during reset
`define BTPC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define BTPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// File: src/btpc_pkg.sv
// Package: shared types and constants for the compensation block
package btpc_pkg;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned RAW_W = 19;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AC1_AC2 = 3'd0,
        CFG_AC3_AC4 = 3'd1,
        CFG_AC5_AC6 = 3'd2,
        CFG_B1_B2   = 3'd3,
        CFG_MC_MD   = 3'd4,
        CFG_OSS     = 3'd5
    } t_cfg_idx;

    localparam logic KIND_TEMP  = 1'b0;
    localparam logic KIND_PRESS = 1'b1;

    localparam logic [31:0] C_4000  = 32'd4000;
    localparam logic [31:0] C_32768 = 32'd32768;
    localparam logic [31:0] C_50000 = 32'd50000;
    localparam logic [31:0] C_3038  = 32'd3038;
    localparam logic [31:0] C_M7357 = 32'hFFFF_E343;
    localparam logic [31:0] C_3791  = 32'd3791;

    // datapath operations issued by the controller
    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_T1,
        OP_T2,
        OP_T3,
        OP_T4,
        OP_T5,
        OP_P1,
        OP_P2,
        OP_P3,
        OP_P4,
        OP_P5,
        OP_P6,
        OP_P7,
        OP_P8,
        OP_P9,
        OP_P10,
        OP_P11,
        OP_P12,
        OP_P13,
        OP_P14,
        OP_P15,
        OP_P16,
        OP_DIV_START,
        OP_DIV_STEP,
        OP_ERR
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_DIV,
        ST_POST,
        ST_OUT
    } t_state;

    typedef struct packed {
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic kind;
        logic den_zero;
    } t_status;

    function automatic logic [31:0] asr32(input logic [31:0] v, input int unsigned n);
        asr32 = 32'($signed(v) >>> n);
    endfunction
endpackage

// File: src/btpc_stream_if.sv
// Interfaces: valid/ready channels for input readings and results
interface btpc_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [18:0] raw_reading;
    modport source (output valid, action, raw_reading, input ready);
    modport sink   (input valid, action, raw_reading, output ready);
endinterface

interface btpc_out_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [31:0] compensated_value;
    logic        divide_error;
    modport source (output valid, result_kind, compensated_value, divide_error,
                    input ready);
    modport sink   (input valid, result_kind, compensated_value, divide_error,
                    output ready);
endinterface

// File: src/baro_temp_pressure_compensation.sv
// Top level: barometric temperature and pressure compensation block
//
// Usage:
//   in_ch  carries one raw reading per transaction: action 0 is a raw
//          temperature (UT), action 1 a raw pressure (UP).
//   out_ch returns one result per input transaction: result_kind copies
//          action, compensated_value is 0.1 degC or Pa, divide_error
//          flags a zero divisor (value then 0).
//   The config port writes calibration words and oversampling; write
//   only while the block is idle.
// Operation: one item at a time. Each run is dominated by the 32-step
//   restoring divider, one quotient bit per cycle, plus one multiply per
//   step through a single shared 32x32 multiplier.
// Reset: coefficients clear, oversampling returns to 3, B5 clears.
// Stall: the result holds in the output register while out ready is low;
//   no new item is accepted until it is taken.
module baro_temp_pressure_compensation (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [btpc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [btpc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    btpc_in_if.sink                           in_ch,
    btpc_out_if.source                        out_ch
);
    import btpc_pkg::*;

    t_cmd    cmd;
    t_status status;

    // sequence the steps
    btpc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_ch.valid),
        .o_in_ready  (in_ch.ready),
        .o_out_valid (out_ch.valid),
        .i_out_ready (out_ch.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // hold state and compute
    btpc_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_action   (in_ch.action),
        .i_raw      (in_ch.raw_reading),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_kind     (out_ch.result_kind),
        .o_value    (out_ch.compensated_value),
        .o_err      (out_ch.divide_error)
    );
endmodule

// File: src/btpc_ctrl.sv
// Controller: sequences the compensation steps and the divider
module btpc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  btpc_pkg::t_status i_status,
    output btpc_pkg::t_cmd    o_cmd
);
    import btpc_pkg::*;

    t_state r_state, n_state;
    t_op    r_step, n_step;
    logic [4:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= OP_NOP;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_step       = r_step;
        n_cnt        = r_cnt;
        o_in_ready   = 1'b0;
        o_out_valid  = 1'b0;
        o_cmd.op       = OP_NOP;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = ST_RUN;
                    n_step   = OP_T1;
                end
            end
            ST_RUN: begin
                o_cmd.op = r_step;
                priority case (r_step)
                    OP_T2: begin
                        if (i_status.den_zero) begin
                            o_cmd.op = OP_ERR;
                            n_state  = ST_OUT;
                        end else begin
                            o_cmd.op = OP_DIV_START;
                            n_state  = ST_DIV;
                            n_cnt    = '0;
                            n_step   = OP_T3;
                        end
                    end
                    OP_P12: begin
                        if (i_status.den_zero) begin
                            o_cmd.op = OP_ERR;
                            n_state  = ST_OUT;
                        end else begin
                            o_cmd.op = OP_DIV_START;
                            n_state  = ST_DIV;
                            n_cnt    = '0;
                            n_step   = OP_P13;
                        end
                    end
                    OP_T1: n_step = OP_T2;
                    OP_T5, OP_P16: n_state = ST_OUT;
                    OP_T3: n_step = OP_T4;
                    OP_T4: n_step = OP_T5;
                    OP_LOAD: n_step = OP_T1;
                    default: n_step = t_op'(r_step + 5'd1);
                endcase
            end
            ST_DIV: begin
                o_cmd.op = OP_DIV_STEP;
                n_cnt    = r_cnt + 5'd1;
                if (r_cnt == 5'd31) n_state = ST_RUN;
            end
            ST_POST: n_state = ST_RUN;
            ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
        // pressure branch begins at P1 after load
        if (r_state == ST_IDLE && i_in_valid && i_status.kind) n_step = OP_P1;
    end
endmodule

// File: src/btpc_dp.sv
// Datapath: coefficient registers, B5, sequential arithmetic and divider
module btpc_dp (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [btpc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [btpc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                    i_action,
    input  logic [18:0]             i_raw,
    input  btpc_pkg::t_cmd          i_cmd,
    output btpc_pkg::t_status       o_status,
    output logic                    o_kind,
    output logic [31:0]             o_value,
    output logic                    o_err
);
    import btpc_pkg::*;

    logic [31:0] r_c0, r_c1, r_c2, r_c3, r_c4;
    logic [1:0]  r_oss;
    logic [31:0] r_b5;
    logic        r_kind, r_err;
    logic [31:0] r_raw, r_a, r_b, r_sq, r_x1, r_x2, r_b3, r_b4, r_b7, r_p, r_den;
    logic [31:0] r_mul;
    // divider
    logic [31:0] r_q, r_rem, r_dvs;
    logic        r_neg, r_post_shl;

    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    assign ac1 = {{16{r_c0[31]}}, r_c0[31:16]};
    assign ac2 = {{16{r_c0[15]}}, r_c0[15:0]};
    assign ac3 = {{16{r_c1[31]}}, r_c1[31:16]};
    assign ac4 = {16'd0, r_c1[15:0]};
    assign ac5 = {16'd0, r_c2[31:16]};
    assign ac6 = {16'd0, r_c2[15:0]};
    assign b1  = {{16{r_c3[31]}}, r_c3[31:16]};
    assign b2  = {{16{r_c3[15]}}, r_c3[15:0]};
    assign mc  = {{16{r_c4[31]}}, r_c4[31:16]};
    assign md  = {{16{r_c4[15]}}, r_c4[15:0]};

    logic [31:0] mul_a, mul_b, mul_y;
    assign mul_y = 32'(mul_a * mul_b);

    logic [32:0] trial;
    assign trial = {r_rem[31:0], r_q[31]} - {1'b0, r_dvs};

    logic [31:0] qfix;
    assign qfix = r_neg ? (32'd0 - r_q) : r_q;

    assign o_status.kind     = i_action;
    assign o_status.den_zero = (r_den == 32'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c0 <= '0; r_c1 <= '0; r_c2 <= '0; r_c3 <= '0; r_c4 <= '0;
            r_oss <= 2'd3;
            r_b5 <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_AC1_AC2: r_c0 <= i_cfg_data;
                CFG_AC3_AC4: r_c1 <= i_cfg_data;
                CFG_AC5_AC6: r_c2 <= i_cfg_data;
                CFG_B1_B2:   r_c3 <= i_cfg_data;
                CFG_MC_MD:   r_c4 <= i_cfg_data;
                CFG_OSS:     r_oss <= i_cfg_data[1:0];
                default: ;
            endcase
        end else if (i_cmd.op == OP_T4) begin
            r_b5 <= r_x1 + qfix;
        end
    end

    // multiplier operands are always r_a and r_b, loaded per step
    always_comb begin
        mul_a = r_a;
        mul_b = r_b;
    end

    always_ff @(posedge i_clk) begin
        r_mul <= mul_y;
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_kind <= i_action;
                r_err  <= 1'b0;
                r_raw  <= {13'd0, i_raw};
                r_den  <= 32'd1;
                r_a    <= i_action ? (r_b5 - C_4000) : ({13'd0, i_raw} - ac6);
                r_b    <= i_action ? (r_b5 - C_4000) : ac5;
            end
            // temperature
            OP_T1: begin
                r_x1  <= asr32(mul_y, 15);
                r_den <= asr32(mul_y, 15) + md;
            end
            OP_T2: ;
            OP_T3: ;
            OP_T4: ;
            OP_T5: r_p <= asr32(r_x1 + qfix + 32'd8, 4);
            // pressure: r_a = r_b = B6 at entry
            OP_P1: begin
                r_sq <= asr32(mul_y, 12);      // B6*B6
                r_b  <= ac2;                    // next: ac2*b6
            end
            OP_P2: begin
                r_x2 <= asr32(mul_y, 11);
                r_b  <= ac3;
            end
            OP_P3: begin
                r_x1 <= asr32(mul_y, 13);       // ac3*b6
                r_a  <= r_sq;
                r_b  <= b2;
            end
            OP_P4: begin
                r_b3 <= asr32(mul_y, 11) + r_x2; // X3 = x1 + x2
                r_b  <= b1;
            end
            OP_P5: begin
                r_x2 <= asr32(mul_y, 16);
                r_b3 <= asr32(32'((ac1 * 32'd4 + r_b3) << r_oss) + 32'd2, 2);
            end
            OP_P6: begin
                r_a <= asr32(r_x1 + r_x2 + 32'd2, 2) + C_32768;
                r_b <= ac4;
            end
            OP_P7: begin
                r_b4 <= 32'(mul_y >> 15);
                r_a  <= r_raw - r_b3;
                r_b  <= C_50000 >> r_oss;
            end
            OP_P8: begin
                r_b7  <= mul_y;
                r_den <= r_b4;
            end
            OP_P9: ;
            OP_P10: ;
            OP_P11: ;
            OP_P12: ;
            OP_P13: begin
                r_p <= r_post_shl ? {r_q[30:0], 1'b0} : r_q;
                r_a <= asr32(r_post_shl ? {r_q[30:0], 1'b0} : r_q, 8);
                r_b <= asr32(r_post_shl ? {r_q[30:0], 1'b0} : r_q, 8);
            end
            OP_P14: begin
                r_a <= mul_y;
                r_b <= C_3038;
            end
            OP_P15: begin
                r_x1 <= asr32(mul_y, 16);
                r_a  <= C_M7357;
                r_b  <= r_p;
            end
            OP_P16: r_p <= r_p + asr32(r_x1 + asr32(mul_y, 16) + C_3791, 4);
            OP_DIV_START: begin
                r_rem <= '0;
                if (r_kind == KIND_TEMP) begin
                    // signed: |MC<<11| / |den|
                    r_q   <= mc[31] ? (32'd0 - (mc << 11)) : (mc << 11);
                    r_dvs <= r_den[31] ? (32'd0 - r_den) : r_den;
                    r_neg <= mc[31] ^ r_den[31];
                    r_post_shl <= 1'b0;
                end else begin
                    r_q   <= r_b7[31] ? r_b7 : {r_b7[30:0], 1'b0};
                    r_dvs <= r_den;
                    r_neg <= 1'b0;
                    r_post_shl <= r_b7[31];
                end
            end
            OP_DIV_STEP: begin
                if (!trial[32]) begin
                    r_rem <= trial[31:0];
                    r_q   <= {r_q[30:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[30:0], r_q[31]};
                    r_q   <= {r_q[30:0], 1'b0};
                end
            end
            OP_ERR: begin
                r_err <= 1'b1;
                r_p   <= '0;
            end
            default: ;
        endcase
    end

    assign o_kind  = r_kind;
    assign o_value = r_p;
    assign o_err   = r_err;

    `include "baro_temp_pressure_compensation_assert.svh"
    `BTPC_ASSERT_NEXT(a_err_zero, i_clk, i_rst_n, i_cmd.op == OP_ERR, r_p == 32'd0 && r_err, "error result must be zero")
    `BTPC_ASSERT_NEXT(a_b5_hold, i_clk, i_rst_n, i_cmd.op == OP_ERR && !i_cfg_we, $stable(r_b5), "B5 changed on divide error")
    `BTPC_ASSERT_IMP(a_div_nonzero, i_clk, i_rst_n, i_cmd.op == OP_DIV_START, r_den != 32'd0, "divide started with zero divisor")
endmodule

// File: tb/baro_temp_pressure_compensation_tb.sv
`timescale 1ns / 1ps
// Testbench for the barometric temperature and pressure compensation block
module baro_temp_pressure_compensation_tb;
    import btpc_pkg::*;

    // Index past the register list; a write to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd6;
    localparam int unsigned DRAIN_CYCLES = 64;
    localparam int unsigned RANDOM_PHASES = 12;
    localparam int unsigned PHASE_READINGS = 158;

    typedef struct packed {
        logic        kind;
        logic [31:0] value;
        logic        err;
    } comp_result_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    btpc_in_if  in_ch ();
    btpc_out_if out_ch ();

    baro_temp_pressure_compensation uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .in_ch      (in_ch),
        .out_ch     (out_ch)
    );

    // Shadow copy of the calibration words, oversampling and kept B5 term.
    logic [31:0] cal_ac1_ac2, cal_ac3_ac4, cal_ac5_ac6, cal_b1_b2, cal_mc_md;
    logic [1:0]  oss_sel;
    logic [31:0] b5_kept;

    comp_result_t expected_results[$];
    int unsigned  fail_count = 0;
    int unsigned  burst_left = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: the slowest legal run is a few ms; give it plenty of room.
    initial begin
        #50ms;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic logic [31:0] shift_right_arith(input logic [31:0] v, input int unsigned n);
        shift_right_arith = 32'($signed(v) >>> n);
    endfunction

    function automatic logic [31:0] sext16(input logic [15:0] h);
        sext16 = {{16{h[15]}}, h};
    endfunction

    // Signed divide truncating toward zero; the most negative over -1 wraps.
    function automatic logic [31:0] div_trunc(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] ma, mb, q;
        ma = a[31] ? (32'd0 - a) : a;
        mb = b[31] ? (32'd0 - b) : b;
        q  = ma / mb;
        div_trunc = (a[31] != b[31]) ? (32'd0 - q) : q;
    endfunction

    // Compensate one raw reading; a good temperature updates the kept B5.
    function automatic comp_result_t compensate_reading(input logic kind,
                                                        input logic [18:0] raw);
        logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, raw_w;
        logic [31:0] x1, x2, x3, den, b5, b6, sq, b3, b4, b7, p;
        comp_result_t r;
        ac1 = sext16(cal_ac1_ac2[31:16]);
        ac2 = sext16(cal_ac1_ac2[15:0]);
        ac3 = sext16(cal_ac3_ac4[31:16]);
        ac4 = {16'd0, cal_ac3_ac4[15:0]};
        ac5 = {16'd0, cal_ac5_ac6[31:16]};
        ac6 = {16'd0, cal_ac5_ac6[15:0]};
        b1  = sext16(cal_b1_b2[31:16]);
        b2  = sext16(cal_b1_b2[15:0]);
        mc  = sext16(cal_mc_md[31:16]);
        md  = sext16(cal_mc_md[15:0]);
        raw_w = {13'd0, raw};
        r.kind  = kind;
        r.value = 32'd0;
        r.err   = 1'b0;
        if (kind == KIND_TEMP) begin
            x1  = shift_right_arith((raw_w - ac6) * ac5, 15);
            den = x1 + md;
            if (den == 32'd0) begin
                r.err = 1'b1;           // keep B5 as it was
            end else begin
                x2 = div_trunc(mc << 11, den);
                b5 = x1 + x2;
                b5_kept = b5;
                r.value = shift_right_arith(b5 + 32'd8, 4);
            end
        end else begin
            b6 = b5_kept - C_4000;
            sq = shift_right_arith(b6 * b6, 12);
            x1 = shift_right_arith(b2 * sq, 11);
            x2 = shift_right_arith(ac2 * b6, 11);
            x3 = x1 + x2;
            b3 = shift_right_arith(((ac1 * 32'd4 + x3) << oss_sel) + 32'd2, 2);
            x1 = shift_right_arith(ac3 * b6, 13);
            x2 = shift_right_arith(b1 * sq, 16);
            x3 = shift_right_arith(x1 + x2 + 32'd2, 2);
            b4 = (ac4 * (x3 + C_32768)) >> 15;
            b7 = (raw_w - b3) * (C_50000 >> oss_sel);
            if (b4 == 32'd0) begin
                r.err = 1'b1;
            end else begin
                // unsigned divide, keeping the top bit of B7 when it is set
                p  = b7[31] ? ((b7 / b4) << 1) : ((b7 << 1) / b4);
                x1 = shift_right_arith(p, 8) * shift_right_arith(p, 8);
                x1 = shift_right_arith(x1 * C_3038, 16);
                x2 = shift_right_arith(C_M7357 * p, 16);
                r.value = p + shift_right_arith(x1 + x2 + C_3791, 4);
            end
        end
        return r;
    endfunction

    // Write one register and mirror it; only called while the block is idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_AC1_AC2: cal_ac1_ac2 = data;
            CFG_AC3_AC4: cal_ac3_ac4 = data;
            CFG_AC5_AC6: cal_ac5_ac6 = data;
            CFG_B1_B2:   cal_b1_b2   = data;
            CFG_MC_MD:   cal_mc_md   = data;
            CFG_OSS:     oss_sel     = data[1:0];
            default: ;
        endcase
    endtask

    task automatic write_calibration(input logic [31:0] w12, input logic [31:0] w34,
                                     input logic [31:0] w56, input logic [31:0] wb,
                                     input logic [31:0] wm, input logic [31:0] wo);
        write_reg(CFG_AC1_AC2, w12);
        write_reg(CFG_AC3_AC4, w34);
        write_reg(CFG_AC5_AC6, w56);
        write_reg(CFG_B1_B2, wb);
        write_reg(CFG_MC_MD, wm);
        write_reg(CFG_OSS, wo);
    endtask

    // Typical factory calibration words, as found on real parts.
    task automatic write_typical_calibration(input logic [1:0] oss);
        write_calibration({16'sd408, -16'sd72}, {-16'sd14383, 16'd32741},
                          {16'd32757, 16'd23153}, {16'sd6190, 16'sd4},
                          {-16'sd8711, 16'sd2868}, {30'd0, oss});
    endtask

    // Send one reading; the sender works in bursts with random gaps between them.
    task automatic send_reading(input logic kind, input logic [18:0] raw);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                @(negedge i_clk);
                in_ch.valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        in_ch.valid       <= 1'b1;
        in_ch.action      <= kind;
        in_ch.raw_reading <= raw;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        expected_results.push_back(compensate_reading(kind, raw));
    endtask

    // Drop valid and wait until every result is back and the block is idle.
    task automatic drain;
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        burst_left = 0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Receiver stall pattern: a randomly drawn mode sets out ready.
    int unsigned stall_mode = 0;
    int unsigned stall_tick = 0;
    always @(negedge i_clk) begin
        if (stall_tick % 64 == 0) stall_mode = $urandom_range(0, 3);
        stall_tick++;
        case (stall_mode)
            0: out_ch.ready <= 1'b1;                             // no stalls
            1: out_ch.ready <= ($urandom_range(0, 1) == 1);
            2: out_ch.ready <= ($urandom_range(0, 15) == 0);     // long stalls
            default: out_ch.ready <= ((stall_tick / 3) % 2 == 0);
        endcase
    end

    // Compare each result transaction with the oldest expectation.
    always @(posedge i_clk) begin
        comp_result_t want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result: kind %0b value %0d err %0b", out_ch.result_kind,
                       $signed(out_ch.compensated_value), out_ch.divide_error);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                if (out_ch.result_kind !== want.kind) begin
                    $error("result_kind: expected %0b, got %0b", want.kind,
                           out_ch.result_kind);
                    fail_count++;
                end
                if (out_ch.compensated_value !== want.value) begin
                    $error("compensated_value: expected %0d, got %0d", $signed(want.value),
                           $signed(out_ch.compensated_value));
                    fail_count++;
                end
                if (out_ch.divide_error !== want.err) begin
                    $error("divide_error: expected %0b, got %0b", want.err,
                           out_ch.divide_error);
                    fail_count++;
                end
            end
        end
    end

    // Reset values: every divisor is zero, so both kinds flag an error.
    task automatic test_reset_state;
        send_reading(KIND_PRESS, 19'd0);
        send_reading(KIND_TEMP, 19'd0);
        send_reading(KIND_TEMP, 19'h7FFFF);
        send_reading(KIND_PRESS, 19'h7FFFF);
        drain();
    endtask

    // Typical calibration through all oversampling settings and raw extremes.
    task automatic test_typical_readings;
        write_typical_calibration(2'd0);
        send_reading(KIND_TEMP, 19'd27898);
        send_reading(KIND_PRESS, 19'd23843);
        send_reading(KIND_PRESS, 19'd0);
        send_reading(KIND_PRESS, 19'h7FFFF);
        drain();
        for (int o = 1; o < 4; o++) begin
            write_reg(CFG_OSS, 32'(o));
            send_reading(KIND_PRESS, 19'd23843 << o);
            drain();
        end
        // write to an unused index: nothing may change
        write_reg(CFG_IDX_UNUSED, 32'hFFFF_FFFF);
        send_reading(KIND_TEMP, 19'h7FFFF);
        send_reading(KIND_TEMP, 19'd0);
        send_reading(KIND_PRESS, 19'd40000);
        drain();
    endtask

    // Zero divisors: the temperature error must leave B5 untouched.
    task automatic test_zero_divisors;
        write_reg(CFG_AC5_AC6, 32'd0);
        write_reg(CFG_MC_MD, {-16'sd8711, 16'd0});
        send_reading(KIND_TEMP, 19'd30000);
        send_reading(KIND_PRESS, 19'd23843);
        drain();
        write_reg(CFG_AC3_AC4, {-16'sd14383, 16'd0});
        send_reading(KIND_PRESS, 19'd23843);
        drain();
        // all-ones calibration words
        write_calibration(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                          32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_reading(KIND_TEMP, 19'h7FFFF);
        send_reading(KIND_PRESS, 19'h7FFFF);
        send_reading(KIND_TEMP, 19'd0);
        send_reading(KIND_PRESS, 19'd0);
        drain();
    endtask

    // Random phases: mostly a temperature followed by a few pressures.
    task automatic test_random_traffic;
        int unsigned sent;
        int unsigned n_press;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph % 3 == 2) begin
                write_calibration($urandom(), $urandom(), $urandom(), $urandom(),
                                  $urandom(), $urandom());
            end else begin
                // words near the typical ones, with some fields drawn from wide ranges
                write_calibration({16'(408 + $urandom_range(0, 255) - 128),
                                   16'(-72 - $urandom_range(0, 63))},
                                  {16'(-14383 + $urandom_range(0, 511)),
                                   16'($urandom_range(20000, 65535))},
                                  {16'($urandom_range(1000, 65535)),
                                   16'($urandom_range(0, 65535))},
                                  {16'($urandom()), 16'($urandom_range(0, 15))},
                                  {16'(-8711 + $urandom_range(0, 1023)),
                                   16'($urandom_range(1, 6000))},
                                  32'($urandom_range(0, 7)));
            end
            sent = 0;
            while (sent < PHASE_READINGS) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_reading(1'($urandom()), 19'($urandom()));
                    sent++;
                end else begin
                    send_reading(KIND_TEMP, ($urandom_range(0, 7) == 0) ?
                                 19'($urandom()) : 19'($urandom_range(15000, 40000)));
                    n_press = $urandom_range(1, 4);
                    for (int k = 0; k < n_press; k++) begin
                        send_reading(KIND_PRESS, 19'($urandom()));
                    end
                    sent += n_press + 1;
                end
            end
            drain();
        end
    endtask

    initial begin
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = CFG_AC1_AC2;
        i_cfg_data        = '0;
        in_ch.valid       = 1'b0;
        in_ch.action      = KIND_TEMP;
        in_ch.raw_reading = '0;
        out_ch.ready      = 1'b0;
        cal_ac1_ac2 = '0;
        cal_ac3_ac4 = '0;
        cal_ac5_ac6 = '0;
        cal_b1_b2   = '0;
        cal_mc_md   = '0;
        oss_sel     = 2'd3;
        b5_kept     = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_typical_readings();
        test_zero_divisors();
        test_random_traffic();

        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
